>>> hw/rtl/md5_message_digest_assert.svh
// Assertion macros for the MD5 digest block.
// Included by the modules that carry concurrent checks.
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH
`ifndef ASSERT_OFF
`define MD5_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define MD5_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define MD5_ASSERT(label, clk, rst, prop)
`define MD5_ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> hw/rtl/md5_pkg.sv
// Package for the MD5 digest block: constants, tables and shared types.
// No dependencies.
package md5_pkg;
  localparam int QueueDepth = 4;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Request passed from front to back
  typedef struct packed {
    logic       fin;
    logic [7:0] data;
  } md5_req_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0: r = 32'hd76aa478;  6'd1: r = 32'he8c7b756;  6'd2: r = 32'h242070db;
      6'd3: r = 32'hc1bdceee;  6'd4: r = 32'hf57c0faf;  6'd5: r = 32'h4787c62a;
      6'd6: r = 32'ha8304613;  6'd7: r = 32'hfd469501;  6'd8: r = 32'h698098d8;
      6'd9: r = 32'h8b44f7af;  6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
      6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193; 6'd14: r = 32'ha679438e;
      6'd15: r = 32'h49b40821; 6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
      6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa; 6'd20: r = 32'hd62f105d;
      6'd21: r = 32'h02441453; 6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
      6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6; 6'd26: r = 32'hf4d50d87;
      6'd27: r = 32'h455a14ed; 6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
      6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a; 6'd32: r = 32'hfffa3942;
      6'd33: r = 32'h8771f681; 6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
      6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9; 6'd38: r = 32'hf6bb4b60;
      6'd39: r = 32'hbebfbc70; 6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
      6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05; 6'd44: r = 32'hd9d4d039;
      6'd45: r = 32'he6db99e5; 6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
      6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97; 6'd50: r = 32'hab9423a7;
      6'd51: r = 32'hfc93a039; 6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
      6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1; 6'd56: r = 32'h6fa87e4f;
      6'd57: r = 32'hfe2ce6e0; 6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
      6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235; 6'd62: r = 32'h2ad7d2bb;
      default: r = 32'heb86d391;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // Message word index used in round i
  function automatic logic [3:0] md5_widx(input logic [5:0] i);
    logic [3:0] r;
    case (i[5:4])
      2'd0: r = i[3:0];
      2'd1: r = 4'(5 * i[3:0] + 1);
      2'd2: r = 4'(3 * i[3:0] + 5);
      default: r = 4'(7 * i[3:0]);
    endcase
    return r;
  endfunction
endpackage

>>> hw/rtl/md5_queue.sv
// Short request queue between the front and the back of the MD5 block.
// Uses md5_pkg.
module md5_queue #(
  parameter int Depth = md5_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_stall,
  input  md5_pkg::md5_req_t wr_req,
  output logic              rd_valid,
  input  logic              rd_stall,
  output md5_pkg::md5_req_t rd_req
);
  import md5_pkg::*;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  md5_req_t         mem [Depth];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      fill;
  logic             do_wr;
  logic             do_rd;

  assign wr_stall = (fill == (AW+1)'(Depth));
  assign rd_valid = (fill != '0);
  assign rd_req   = mem[rptr];
  assign do_wr    = wr_valid && !wr_stall;
  assign do_rd    = rd_valid && !rd_stall;

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wr_req;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + 1'b1;
      if (do_rd) rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + 1'b1;
      fill <= fill + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end
endmodule

>>> hw/rtl/md5_front.sv
// Front end: accepts requests, classifies absorb and finish, feeds the queue.
// Uses md5_pkg.
module md5_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  logic              op,
  input  logic [7:0]        data_byte,
  output logic              q_valid,
  input  logic              q_stall,
  output md5_pkg::md5_req_t q_req
);
  import md5_pkg::*;

  // Registered front stage
  logic     hold;
  md5_req_t req;

  assign stall   = hold && q_stall;
  assign q_valid = hold;
  assign q_req   = req;

  always_ff @(posedge clk) begin
    if (rst) hold <= 1'b0;
    else if (!stall) hold <= valid;
  end

  always_ff @(posedge clk) begin
    if (!stall && valid) begin
      req.fin  <= (op == OP_FINISH);
      req.data <= (op == OP_FINISH) ? 8'h80 : data_byte;
    end
  end
endmodule

>>> hw/rtl/md5_core.sv
// Back end: block buffer, byte counter, padding sequencer, 64-round engine
// and digest output register. Uses md5_pkg and the assertion macros.
`include "md5_message_digest_assert.svh"
module md5_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_stall,
  input  md5_pkg::md5_req_t q_req,
  output logic              valid,
  input  logic              stall,
  output logic [7:0]        digest_byte,
  output logic              last_digest
);
  import md5_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PAD  = 5'b00010,
    S_LOAD = 5'b00100,
    S_RND  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t       state;
  logic [60:0]  byte_count;
  logic [63:0]  bits;
  logic [5:0]   pos;
  logic         fin;
  logic         len_blk;
  logic [31:0]  cv [4];
  logic [31:0]  a, b, c, d;
  logic [5:0]   rnd;
  logic [3:0]   outn;
  logic [31:0]  buf_mem [16];
  logic [31:0]  w;
  logic [7:0]   pad_byte;
  logic         wr_en;
  logic [5:0]   wr_pos;
  logic [7:0]   wr_byte;
  logic [31:0]  f;
  logic [31:0]  sum;
  logic [31:0]  rot;
  logic [31:0]  cv_sel;

  assign q_stall = (state != S_IDLE);

  // Padding byte at the current position; the length goes only in the block flagged by len_blk
  always_comb begin
    if (len_blk && pos >= 6'd56) pad_byte = bits[8*(pos[2:0]) +: 8];
    else pad_byte = 8'h00;
  end

  assign wr_en   = (state == S_IDLE && q_valid) || state == S_PAD;
  assign wr_pos  = pos;
  assign wr_byte = (state == S_IDLE) ? q_req.data : pad_byte;

  // Block buffer as 16 words, byte-lane writes
  always_ff @(posedge clk) begin
    if (wr_en) buf_mem[wr_pos[5:2]][8*wr_pos[1:0] +: 8] <= wr_byte;
  end

  // Registered message word for the next round
  always_ff @(posedge clk) begin
    w <= buf_mem[md5_widx((state == S_RND) ? rnd + 6'd1 : 6'd0)];
  end

  // Round function
  always_comb begin
    case (rnd[5:4])
      2'd0: f = d ^ (b & (c ^ d));
      2'd1: f = c ^ (d & (b ^ c));
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum = a + f + md5_k(rnd) + w;
    rot = (sum << md5_rot(rnd)) | (sum >> (6'd32 - {1'b0, md5_rot(rnd)}));
  end

  assign cv_sel      = cv[outn[3:2]];
  assign digest_byte = cv_sel[8*outn[1:0] +: 8];
  assign last_digest = (outn == 4'd15);
  assign valid       = (state == S_OUT);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_count <= '0;
      pos        <= '0;
      fin        <= 1'b0;
      len_blk    <= 1'b0;
      rnd        <= '0;
      outn       <= '0;
      cv[0] <= IV_A; cv[1] <= IV_B; cv[2] <= IV_C; cv[3] <= IV_D;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            pos <= pos + 6'd1;
            fin <= q_req.fin;
            if (q_req.fin) begin
              bits <= {byte_count, 3'b000};
              // Length fits after the pad byte only below offset 56
              len_blk <= (pos < 6'd56);
              if (pos == 6'd63) state <= S_LOAD;
              else state <= S_PAD;
            end else begin
              byte_count <= byte_count + 61'd1;
              if (pos == 6'd63) state <= S_LOAD;
            end
          end
        end
        S_PAD: begin
          pos <= pos + 6'd1;
          if (pos == 6'd63) state <= S_LOAD;
        end
        S_LOAD: begin
          a <= cv[0]; b <= cv[1]; c <= cv[2]; d <= cv[3];
          rnd <= '0;
          state <= S_RND;
        end
        S_RND: begin
          a <= d; d <= c; c <= b; b <= b + rot;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            cv[0] <= cv[0] + d;
            cv[1] <= cv[1] + b + rot;
            cv[2] <= cv[2] + b;
            cv[3] <= cv[3] + c;
            if (!fin) state <= S_IDLE;
            else if (!len_blk) begin
              // Pad byte filled the first block: length goes in a second one
              len_blk <= 1'b1;
              state   <= S_PAD;
            end else begin
              state <= S_OUT;
              outn  <= '0;
            end
          end
        end
        S_OUT: begin
          if (!stall) begin
            outn <= outn + 4'd1;
            if (outn == 4'd15) begin
              state <= S_IDLE;
              byte_count <= '0;
              pos <= '0;
              fin <= 1'b0;
              cv[0] <= IV_A; cv[1] <= IV_B; cv[2] <= IV_C; cv[3] <= IV_D;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MD5_ASSERT(a_out_only_fin, clk, rst, valid |-> fin)
  `MD5_ASSERT(a_rnd_from_load, clk, rst, $rose(state == S_RND) |-> $past(state == S_LOAD))
  `MD5_ASSERT(a_last_leaves, clk, rst, (valid && !stall && last_digest) |=> state == S_IDLE)
endmodule

>>> hw/rtl/md5_message_digest.sv
// MD5 digest block: one byte per request, 64-round compression per block.
// Absorb: bytes enter while the core is idle; a full block adds a load step and 64 rounds (one per cycle).
// Finish: pad bytes one per cycle, one or two compressions, then 16 digest bytes.
// First digest byte is offered once the last compression ends; the 16 bytes then
// leave one per cycle while out_stall is low.
// Synchronous active-high reset restores the initial vector and a zero count.
module md5_message_digest #(
  parameter int QueueDepth = md5_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] digest_byte,
  output logic       last_digest
);
  import md5_pkg::*;

  logic     f_valid, f_stall, c_valid, c_stall;
  md5_req_t f_req, c_req;

  md5_front u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .op, .data_byte,
    .q_valid(f_valid), .q_stall(f_stall), .q_req(f_req)
  );

  md5_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_req(f_req),
    .rd_valid(c_valid), .rd_stall(c_stall), .rd_req(c_req)
  );

  md5_core u_core (
    .clk, .rst, .q_valid(c_valid), .q_stall(c_stall), .q_req(c_req),
    .valid(out_valid), .stall(out_stall), .digest_byte, .last_digest
  );
endmodule
